[hw/rtl/fwhi_pkg.sv]
// Shared types and constants for the filter wheel homing indexer.
package fwhi_pkg;

  localparam int unsigned PosW = 8;
  localparam int unsigned SmpW = 12;
  localparam int unsigned CfgW = 12;

  // Highest filter number on the wheel; home in reverse loads this value.
  localparam logic [PosW-1:0] TopIndex = PosW'(7);
  localparam logic [PosW-1:0] TopHalf  = PosW'(TopIndex / 2);

  localparam logic [SmpW-1:0] HighThrRst = SmpW'(3225);
  localparam logic [SmpW-1:0] LowThrRst  = SmpW'(1000);

  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_MOTION = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_HOME   = 2'd3
  } req_e;

  typedef enum logic {
    CFG_HIGH_THR = 1'b0,
    CFG_LOW_THR  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_PRECHECK = 3'b001,
    PH_TOHOME   = 3'b010,
    PH_FIND     = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [PosW-1:0] target;
    logic [PosW-1:0] pos;
    logic            armed;
    logic            dir;
    logic            active;
    logic            motor;
  } wheel_st_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            busy_res;
    logic            arrived;
    logic            motor_dir;
    logic            motor_on;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

endpackage

[hw/rtl/fwhi_step.sv]
// Next-state and result logic for one request.
module fwhi_step
  import fwhi_pkg::*;
(
  input  req_e            req_i,
  input  logic [PosW-1:0] dest_pos_i,
  input  logic [SmpW-1:0] index_sample_i,
  input  logic [SmpW-1:0] high_thr_i,
  input  logic [SmpW-1:0] low_thr_i,
  input  wheel_st_t       cur_i,
  output wheel_st_t       nxt_o,
  output result_t         res_o
);

  logic [PosW-1:0] pos_step;
  logic            arrived;

  assign pos_step = cur_i.dir ? (cur_i.pos - PosW'(1)) : (cur_i.pos + PosW'(1));

  always_comb begin
    nxt_o   = cur_i;
    arrived = 1'b0;
    unique case (req_i)
      REQ_MOVE: begin
        nxt_o.phase  = PH_PRECHECK;
        nxt_o.dir    = (dest_pos_i > TopHalf);
        nxt_o.target = dest_pos_i;
        nxt_o.armed  = 1'b0;
        nxt_o.active = 1'b1;
      end
      REQ_MOTION: begin
        if (cur_i.active && cur_i.phase == PH_PRECHECK) begin
          nxt_o.phase = PH_TOHOME;
          nxt_o.motor = 1'b1;
        end
      end
      REQ_HOME: begin
        if (cur_i.active && (cur_i.phase == PH_PRECHECK || cur_i.phase == PH_TOHOME)) begin
          nxt_o.pos = cur_i.dir ? TopIndex : '0;
          if (cur_i.target == '0) begin
            nxt_o.active = 1'b0;
            nxt_o.motor  = 1'b0;
            arrived      = 1'b1;
          end else begin
            if (cur_i.phase == PH_PRECHECK) nxt_o.motor = 1'b1;
            nxt_o.phase = PH_FIND;
          end
        end
      end
      REQ_SAMPLE: begin
        if (cur_i.active && cur_i.phase == PH_FIND) begin
          if (cur_i.armed) begin
            if (index_sample_i < low_thr_i) begin
              nxt_o.pos = pos_step;
              if (pos_step == cur_i.target) begin
                nxt_o.active = 1'b0;
                nxt_o.motor  = 1'b0;
                arrived      = 1'b1;
              end else begin
                nxt_o.armed = 1'b0;
              end
            end
          end else if (index_sample_i > high_thr_i) begin
            nxt_o.armed = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.position  = nxt_o.pos;
  assign res_o.busy_res  = nxt_o.active;
  assign res_o.arrived   = arrived;
  assign res_o.motor_dir = nxt_o.dir;
  assign res_o.motor_on  = nxt_o.motor;

endmodule

[hw/rtl/fwhi_outreg.sv]
// Result register with valid flag for the master-side stream.
module fwhi_outreg
  import fwhi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    tready_i,
  output logic    tvalid_o,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign vld_d = load_i | (vld_q & ~tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o = vld_q;
  assign res_o    = res_q;

endmodule

[hw/rtl/filter_wheel_homing_indexer.sv]
// Top level of the filter wheel homing indexer.
//
// Slave stream s_axis carries requests: tuser holds the request kind (move,
// motion detected, index sample, home event), tdata the destination filter
// and the 12-bit index sensor sample. Every request yields exactly one
// result on m_axis: motor on, direction, arrival flag, busy and the counted
// position, all reflecting the state after that request.
//
// A request passes through the input register, then the result register.
// Throughput is one request per cycle while the receiver does not stall;
// the state update of each request lands in the same cycle its result is
// registered, so the next request sees it without a bubble.
//
// If the receiver stalls, the result register holds and the input register
// takes one more request; s_axis_tready drops only when both are full.
//
// Reset clears the wheel state (idle, motor off, position 0, clockwise) and
// restores the index thresholds to 3225 (arm) and 1000 (count). The cfg port
// writes one threshold at a time; write it only while no request is pending.
module filter_wheel_homing_indexer
  import fwhi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration writes
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  // Request stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // [7:0] dest_pos, [19:8] index_sample, zero pad
  input  logic [1:0]      s_axis_tuser,   // [1:0] req_type
  // Result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata    // [0] motor_on, [1] motor_dir, [2] arrived,
                                          // [3] busy_res, [11:4] position, zero pad
);

  // Threshold registers
  logic [SmpW-1:0] high_thr_q, low_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HighThrRst;
      low_thr_q  <= LowThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HIGH_THR: high_thr_q <= cfg_wdata_i;
        CFG_LOW_THR:  low_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic            in_vld_q, in_vld_d;
  req_e            req_q;
  logic [PosW-1:0] dest_q;
  logic [SmpW-1:0] smp_q;
  logic            s_acc, adv, out_vld;

  assign adv           = in_vld_q & (~out_vld | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign in_vld_d      = s_acc | (in_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q  <= req_e'(s_axis_tuser);
      dest_q <= s_axis_tdata[PosW-1:0];
      smp_q  <= s_axis_tdata[PosW +: SmpW];
    end
  end

  // Wheel state, updated when a request moves into the result register
  wheel_st_t st_q, st_d;
  result_t   res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_PRECHECK, target: '0, pos: '0, armed: 1'b0,
                dir: 1'b0, active: 1'b0, motor: 1'b0};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  fwhi_step u_step (
    .req_i          (req_q),
    .dest_pos_i     (dest_q),
    .index_sample_i (smp_q),
    .high_thr_i     (high_thr_q),
    .low_thr_i      (low_thr_q),
    .cur_i          (st_q),
    .nxt_o          (st_d),
    .res_o          (res_d)
  );

  fwhi_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .res_i    (res_d),
    .tready_i (m_axis_tready),
    .tvalid_o (out_vld),
    .res_o    (res_q)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {4'b0000, res_q.position, res_q.busy_res, res_q.arrived,
                          res_q.motor_dir, res_q.motor_on};

endmodule

[hw/rtl/fwhi_chk.sv]
// Port-level checks for the filter wheel homing indexer.
module fwhi_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A fresh result always follows an accepted request
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a request");

  // Arrival ends the move and stops the motor
  a_arr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[3] && !m_axis_tdata[0])
    else $error("arrival with move still active");

  // Motor only runs during a move
  a_mot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> !m_axis_tdata[0])
    else $error("motor on while idle");

endmodule

bind filter_wheel_homing_indexer fwhi_chk u_fwhi_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_filter_wheel_homing_indexer.sv]
// Self-checking testbench for the filter wheel homing indexer.
module tb_filter_wheel_homing_indexer
  import fwhi_pkg::*;
();

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int unsigned StallLimit = 3000;
  // Result count at which the receiver takes one long break.
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldCycles = 90;
  // Settling time after the last result, covering input and result register.
  localparam int unsigned Latency    = 4;

  // Tracks the wheel state from the accepted requests and holds the status
  // words the block owes us, oldest first.
  class wheel_status_board;
    logic [SmpW-1:0] arm_thr;
    logic [SmpW-1:0] count_thr;
    phase_e          ph;
    logic [PosW-1:0] tgt;
    logic [PosW-1:0] pos;
    logic            armed;
    logic            dir;
    logic            active;
    logic            motor;
    result_t         expected_status[$];
    int unsigned     mismatches;

    function new();
      arm_thr    = HighThrRst;
      count_thr  = LowThrRst;
      ph         = PH_PRECHECK;
      tgt        = '0;
      pos        = '0;
      armed      = 1'b0;
      dir        = 1'b0;
      active     = 1'b0;
      motor      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_thresholds(logic [SmpW-1:0] hi, logic [SmpW-1:0] lo);
      arm_thr   = hi;
      count_thr = lo;
    endfunction

    function void predict_request(req_e kind, logic [PosW-1:0] dest, logic [SmpW-1:0] smp);
      result_t r;
      r.arrived = 1'b0;
      if (kind == REQ_MOVE) begin
        // a move always restarts precheck, even mid-move; motor keeps its state
        ph     = PH_PRECHECK;
        dir    = (dest > TopHalf);
        tgt    = dest;
        armed  = 1'b0;
        active = 1'b1;
      end else if (active) begin
        case (kind)
          REQ_MOTION: begin
            if (ph == PH_PRECHECK) begin
              ph    = PH_TOHOME;
              motor = 1'b1;
            end
          end
          REQ_HOME: begin
            if (ph == PH_PRECHECK || ph == PH_TOHOME) begin
              pos = dir ? TopIndex : '0;
              if (tgt == '0) begin
                active    = 1'b0;
                motor     = 1'b0;
                r.arrived = 1'b1;
              end else begin
                if (ph == PH_PRECHECK) motor = 1'b1;
                ph = PH_FIND;
              end
            end
          end
          default: begin
            if (ph == PH_FIND) begin
              if (armed) begin
                if (smp < count_thr) begin
                  pos = dir ? pos - 1'b1 : pos + 1'b1;
                  if (pos == tgt) begin
                    active    = 1'b0;
                    motor     = 1'b0;
                    r.arrived = 1'b1;
                  end else begin
                    armed = 1'b0;
                  end
                end
              end else if (smp > arm_thr) begin
                armed = 1'b1;
              end
            end
          end
        endcase
      end
      r.motor_on  = motor;
      r.motor_dir = dir;
      r.busy_res  = active;
      r.position  = pos;
      expected_status.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: want on=%0b dir=%0b arr=%0b busy=%0b pos=%0d, got on=%0b dir=%0b arr=%0b busy=%0b pos=%0d",
                 what, want.motor_on, want.motor_dir, want.arrived, want.busy_res, want.position,
                 got.motor_on, got.motor_dir, got.arrived, got.busy_res, got.position);
    endfunction

    function void check_result(logic [15:0] data);
      result_t got;
      result_t want;
      got = data[ResW-1:0];
      if (expected_status.size() == 0) begin
        want = '0;
        report("unexpected result", want, got);
      end else begin
        want = expected_status.pop_front();
        if (got.motor_on !== want.motor_on || got.motor_dir !== want.motor_dir ||
            got.arrived !== want.arrived || got.busy_res !== want.busy_res ||
            got.position !== want.position)
          report("status mismatch", want, got);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata;   // [7:0] dest_pos, [19:8] index_sample, zero pad
  logic [1:0]      s_axis_tuser;   // [1:0] req_type
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [15:0]     m_axis_tdata;   // [0] motor_on, [1] motor_dir, [2] arrived,
                                   // [3] busy_res, [11:4] position, zero pad

  wheel_status_board board;
  int unsigned       requests_sent;
  int unsigned       results_seen;
  int unsigned       quiet_cycles;
  bit                no_gaps;
  bit                held_off;

  filter_wheel_homing_indexer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Per-request idle time for either side; zero during burst stretches.
  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(18, 0);
  endfunction

  // Sample that arms the detector under the current high threshold, if any can.
  function automatic logic [SmpW-1:0] arming_sample(logic [SmpW-1:0] thr);
    if (thr == '1) return SmpW'($urandom);
    return SmpW'($urandom_range(4095, int'(thr) + 1));
  endfunction

  // Sample that counts a mark under the current low threshold, if any can.
  function automatic logic [SmpW-1:0] marking_sample(logic [SmpW-1:0] thr);
    if (thr == '0) return SmpW'($urandom);
    return SmpW'($urandom_range(int'(thr) - 1, 0));
  endfunction

  // Offer one request, starting at a falling edge; returns at the falling
  // edge after acceptance with tvalid still high, so back-to-back requests
  // never drop valid in between.
  task automatic send_request(req_e kind, logic [PosW-1:0] dest, logic [SmpW-1:0] smp);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, smp, dest};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.predict_request(kind, dest, smp);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Random request of any kind with random content.
  task automatic send_noise();
    send_request(req_e'($urandom_range(3, 0)), PosW'($urandom), SmpW'($urandom));
  endtask

  // Stop offering, let every owed result arrive, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_status.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  // Both thresholds, one write each; only called with the block drained.
  task automatic write_thresholds(logic [SmpW-1:0] hi, logic [SmpW-1:0] lo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HIGH_THR;
    cfg_wdata_i <= hi;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LOW_THR;
    cfg_wdata_i <= lo;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_thresholds(hi, lo);
  endtask

  // Mostly complete moves (move, motion, home, then arm/mark sample pairs
  // until arrival or a cap), mixed with runs of random requests.
  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    logic [PosW-1:0] dest;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(9, 0) < 8) begin
        pick = $urandom_range(7, 0);
        if (pick <= 4)      dest = PosW'($urandom_range(7, 0));
        else if (pick == 5) dest = PosW'($urandom_range(255, 248));  // wraps below zero
        else if (pick == 6) dest = PosW'($urandom);
        else                dest = PosW'($urandom_range(12, 8));     // past the top index
        send_request(REQ_MOVE, dest, SmpW'($urandom));
        if ($urandom_range(3, 0) != 0) send_request(REQ_MOTION, PosW'($urandom), SmpW'($urandom));
        if ($urandom_range(7, 0) == 0) send_noise();
        send_request(REQ_HOME, PosW'($urandom), SmpW'($urandom));
        for (k = 0; k < 24 && board.active; k++) begin
          send_request(REQ_SAMPLE, PosW'($urandom), arming_sample(board.arm_thr));
          if ($urandom_range(5, 0) == 0) send_noise();
          send_request(REQ_SAMPLE, PosW'($urandom), marking_sample(board.count_thr));
        end
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_noise();
      end
    end
  endtask

  // Receiver: random stall before each result, plus one long hold-off so
  // both pipeline registers fill and s_axis_tready drops.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = draw_gap();
      if (results_seen == HoldAt && !held_off) begin
        held_off = 1'b1;
        stall    = HoldCycles;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_filter_wheel_homing_indexer NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HIGH_THR;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_MOVE;
    requests_sent = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    no_gaps       = 1'b0;
    held_off      = 1'b0;
    board         = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, reset thresholds.
    // events while idle are ignored
    send_request(REQ_SAMPLE, 8'hFF, 12'hFFF);
    send_request(REQ_HOME, 8'h00, 12'h000);
    send_request(REQ_MOTION, 8'hFF, 12'hFFF);
    // zero target: home stops at once with arrival
    send_request(REQ_MOVE, 8'h00, 12'hFFF);
    send_request(REQ_HOME, 8'hFF, 12'h000);
    // clockwise move at the half-way boundary
    send_request(REQ_MOVE, TopHalf, 12'h000);
    send_request(REQ_SAMPLE, 8'h00, 12'hFFF);    // sample outside find
    send_request(REQ_MOTION, 8'h00, 12'h000);
    send_request(REQ_MOTION, 8'h00, 12'h000);    // motion outside precheck
    send_request(REQ_HOME, 8'h00, 12'h000);      // home from to-home
    send_request(REQ_HOME, 8'h00, 12'h000);      // home in find
    send_request(REQ_SAMPLE, 8'h00, 12'hFFF);    // arm
    send_request(REQ_SAMPLE, 8'h00, 12'd2000);   // between thresholds
    send_request(REQ_SAMPLE, 8'h00, 12'h000);    // mark
    send_request(REQ_SAMPLE, 8'h00, HighThrRst + 1'b1);
    send_request(REQ_SAMPLE, 8'h00, LowThrRst - 1'b1);
    send_request(REQ_SAMPLE, 8'h00, HighThrRst); // exactly at threshold, no arm
    // move while moving, counter-clockwise, home straight from precheck
    send_request(REQ_MOVE, 8'hFF, 12'h000);
    send_request(REQ_HOME, 8'h00, 12'hFFF);
    send_request(REQ_SAMPLE, 8'h00, 12'hFFF);
    send_request(REQ_SAMPLE, 8'h00, LowThrRst);  // exactly at threshold, no mark
    send_request(REQ_SAMPLE, 8'h00, 12'h000);
    send_request(REQ_MOVE, TopHalf + 1'b1, 12'h000);
    send_request(REQ_HOME, 8'h00, 12'h000);
    run_random(80);

    // Nothing can arm or count.
    drain();
    write_thresholds(12'hFFF, 12'h000);
    no_gaps = 1'b1;
    run_random(40);

    // Every sample above zero arms, every sample below 4095 counts.
    drain();
    write_thresholds(12'h000, 12'hFFF);
    no_gaps = 1'b0;
    run_random(70);

    drain();
    write_thresholds(SmpW'($urandom), SmpW'($urandom));
    run_random(60);

    drain();
    write_thresholds(SmpW'($urandom), SmpW'($urandom));
    no_gaps = 1'b1;
    run_random(50);

    drain();
    write_thresholds(HighThrRst, LowThrRst);
    no_gaps = 1'b0;
    run_random(60);

    drain();
    if (board.mismatches == 0 && board.expected_status.size() == 0) begin
      $display("tb_filter_wheel_homing_indexer OK");
    end else begin
      $display("tb_filter_wheel_homing_indexer NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fwhi_pkg.sv
hw/rtl/fwhi_step.sv
hw/rtl/fwhi_outreg.sv
hw/rtl/filter_wheel_homing_indexer.sv
hw/rtl/fwhi_chk.sv
verif/tb_filter_wheel_homing_indexer.sv
